@@ rtl/rgbcf_pkg.sv @@
// Shared types, widths and register codes of the RGB 3x3 convolution filter.
`timescale 1ns / 1ps

package rgbcf_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int COEF_BITS  = 16;
  localparam int FRAC_BITS  = COEF_BITS - 4;
  localparam int ROW_BITS   = 48;
  localparam int PROD_W     = CH_W + 1 + COEF_BITS;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int ACC_W      = RSUM_W + 2;
  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int CMP_W      = 17;
  localparam int IDX_W      = 3;
  localparam int DEF_MAX_WIDTH = 4096;

  localparam logic [ROW_BITS-1:0] KERNEL_TOP_RST    = 48'hFE39FE39FE39;
  localparam logic [ROW_BITS-1:0] KERNEL_MIDDLE_RST = 48'hFE391E39FE39;
  localparam logic [ROW_BITS-1:0] KERNEL_BOTTOM_RST = 48'hFE39FE39FE39;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST         = 13'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST        = 16'd480;

  typedef enum logic [IDX_W-1:0] {
    REG_KERNEL_TOP    = 3'd0,
    REG_KERNEL_MIDDLE = 3'd1,
    REG_KERNEL_BOTTOM = 3'd2,
    REG_IMAGE_WIDTH   = 3'd3,
    REG_IMAGE_HEIGHT  = 3'd4
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;
  typedef logic [2:0][ROW_BITS-1:0] kernel_t;

  typedef struct packed {
    logic valid;
    logic row_end;
    logic frame_end;
  } win_ctrl_t;

endpackage

@@ rtl/rgbcf_window.sv @@
// Raster counters, two-row line memory and the 3x3 pixel window.
`timescale 1ns / 1ps

module rgbcf_window #(
  parameter int MAX_WIDTH = rgbcf_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rgbcf_pkg::pix_t                pix_in,
  input  logic                           frame_start,
  input  logic [rgbcf_pkg::WIDTH_W-1:0]  image_width,
  input  logic [rgbcf_pkg::HEIGHT_W-1:0] image_height,
  output rgbcf_pkg::window_t             win,
  output rgbcf_pkg::win_ctrl_t           win_ctrl,
  input  logic                           win_ready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW = rgbcf_pkg::PIX_W;
  localparam int HW = rgbcf_pkg::HEIGHT_W;
  localparam int MW = rgbcf_pkg::CMP_W;

  logic [CW-1:0] col_cnt;
  logic [HW-1:0] row_cnt;

  logic [CW-1:0] col_now;
  logic [HW-1:0] row_now;
  logic [MW-1:0] w_eff;
  logic [MW-1:0] h_eff;
  logic          last_col;
  logic          last_row;
  logic          emit_now;
  logic          in_fire;

  logic          v1;
  logic [PW-1:0] pix1;
  logic [CW-1:0] col1;
  logic          emit1;
  logic          rend1;
  logic          fend1;

  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_mem;
  logic [2*PW-1:0] fwd_data;
  logic            fwd_q;
  logic [2*PW-1:0] rd_pair;
  logic [2*PW-1:0] wr_data;

  logic          en2;
  rgbcf_pkg::window_t   win_q;
  rgbcf_pkg::win_ctrl_t ctrl_q;

  always_comb begin
    w_eff = MW'(image_width);
    if (w_eff < MW'(3)) w_eff = MW'(3);
    if (w_eff > MW'(MAX_WIDTH)) w_eff = MW'(MAX_WIDTH);
    h_eff = MW'(image_height);
    if (h_eff < MW'(3)) h_eff = MW'(3);
  end

  assign col_now  = frame_start ? '0 : col_cnt;
  assign row_now  = frame_start ? '0 : row_cnt;
  assign last_col = (MW'(col_now) + MW'(1)) >= w_eff;
  assign last_row = (MW'(row_now) + MW'(1)) >= h_eff;
  assign emit_now = (row_now >= HW'(2)) && (MW'(col_now) >= MW'(2));

  assign en2      = !ctrl_q.valid || win_ready;
  assign in_ready = !v1 || en2;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_now + HW'(1);
      end else begin
        col_cnt <= col_now + CW'(1);
        row_cnt <= row_now;
      end
    end
  end

  // The entry at a column holds the two previous rows. The item in stage one
  // writes its column back as it moves on, so a read of that same column
  // takes the new data instead of the memory.
  assign rd_pair = fwd_q ? fwd_data : rd_mem;
  assign wr_data = {rd_pair[PW-1:0], pix1};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_mem   <= line_mem[col_now];
      fwd_q    <= v1 && (col1 == col_now);
      fwd_data <= wr_data;
    end
    if (v1 && en2) begin
      line_mem[col1] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix1  <= pix_in;
      col1  <= col_now;
      emit1 <= emit_now;
      rend1 <= last_col;
      fend1 <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_q  <= '0;
      ctrl_q <= '0;
    end else if (en2) begin
      ctrl_q.valid     <= v1 && emit1;
      ctrl_q.row_end   <= rend1;
      ctrl_q.frame_end <= fend1;
      if (v1) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= rd_pair[2*PW-1:PW];
        win_q[1][2] <= rd_pair[PW-1:0];
        win_q[2][2] <= pix1;
      end
    end
  end

  assign win      = win_q;
  assign win_ctrl = ctrl_q;

`ifndef SYNTH
  a_frame_start_restarts: assert property (@(posedge clk) disable iff (rst)
    in_fire && frame_start |=> (col_cnt == CW'(1)) && (row_cnt == '0))
    else $error("frame start did not restart the raster counters");

  a_stall_means_busy: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v1 && ctrl_q.valid && !win_ready)
    else $error("input stalled with a free stage");

  a_window_holds: assert property (@(posedge clk) disable iff (rst)
    ctrl_q.valid && !win_ready |=> $stable(win_q) && ctrl_q.valid)
    else $error("window changed while its beat was stalled");
`endif

endmodule

@@ rtl/rgbcf_mac.sv @@
// Per-channel 3x3 multiply, row sums, final sum with clamp, and result register.
`timescale 1ns / 1ps

module rgbcf_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  rgbcf_pkg::kernel_t         kernel,
  input  rgbcf_pkg::window_t         win,
  input  rgbcf_pkg::win_ctrl_t       win_ctrl,
  output logic                       win_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rgbcf_pkg::CH_W-1:0] red_out,
  output logic [rgbcf_pkg::CH_W-1:0] green_out,
  output logic [rgbcf_pkg::CH_W-1:0] blue_out,
  output logic                       row_end,
  output logic                       frame_end
);

  localparam int CB = rgbcf_pkg::COEF_BITS;
  localparam int CHW = rgbcf_pkg::CH_W;
  localparam int PRW = rgbcf_pkg::PROD_W;
  localparam int RSW = rgbcf_pkg::RSUM_W;
  localparam int ACW = rgbcf_pkg::ACC_W;
  localparam int FB = rgbcf_pkg::FRAC_BITS;
  localparam int QW = ACW - FB;

  logic en_o;
  logic en4;
  logic en3;

  logic v3;
  logic rend3;
  logic fend3;
  logic signed [PRW-1:0] prod      [3][3][3];
  logic signed [PRW-1:0] prod_next [3][3][3];

  logic v4;
  logic rend4;
  logic fend4;
  logic signed [RSW-1:0] rsum      [3][3];
  logic signed [RSW-1:0] rsum_next [3][3];

  logic signed [ACW-1:0] acc [3];
  logic [QW-1:0]         quo [3];
  logic [CHW-1:0]        clip [3];

  logic [CHW-1:0] ch_q [3];
  logic           ov;
  logic           rend_q;
  logic           fend_q;

  assign en_o      = !ov || out_ready;
  assign en4       = !v4 || en_o;
  assign en3       = !v3 || en4;
  assign win_ready = en3;

  always_comb begin
    logic signed [CB-1:0] coef;
    logic [CHW-1:0]       px;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          coef = kernel[r][(2-c)*CB +: CB];
          px   = win[r][c][(2-ch)*CHW +: CHW];
          prod_next[ch][r][c] = PRW'($signed({1'b0, px}) * coef);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rsum_next[ch][r] = RSW'(prod[ch][r][0]) + RSW'(prod[ch][r][1])
                         + RSW'(prod[ch][r][2]);
      end
    end
  end

  // A sum at or below zero gives black; otherwise the fraction is dropped
  // and the integer part saturates at full scale.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = ACW'(rsum[ch][0]) + ACW'(rsum[ch][1]) + ACW'(rsum[ch][2]);
      quo[ch] = QW'(acc[ch] >>> FB);
      if (acc[ch] <= 0) begin
        clip[ch] = '0;
      end else if (quo[ch] > QW'(255)) begin
        clip[ch] = '1;
      end else begin
        clip[ch] = quo[ch][CHW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (en3) v3 <= win_ctrl.valid;
      if (en4) v4 <= v3;
      if (en_o) ov <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && win_ctrl.valid) begin
      prod  <= prod_next;
      rend3 <= win_ctrl.row_end;
      fend3 <= win_ctrl.frame_end;
    end
    if (en4 && v3) begin
      rsum  <= rsum_next;
      rend4 <= rend3;
      fend4 <= fend3;
    end
    if (en_o && v4) begin
      ch_q   <= clip;
      rend_q <= rend4;
      fend_q <= fend4;
    end
  end

  assign out_valid = ov;
  assign red_out   = ch_q[0];
  assign green_out = ch_q[1];
  assign blue_out  = ch_q[2];
  assign row_end   = rend_q;
  assign frame_end = fend_q;

`ifndef SYNTH
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    ov |-> !fend_q || rend_q)
    else $error("frame end flagged off a row end");
`endif

endmodule

@@ rtl/rgb_3x3_convolution_filter_top.sv @@
// Top level of the RGB 3x3 convolution filter: configuration registers and datapath.
//
// Channel   Handshake              Beat contents
// input     in_valid / in_ready    red_in, green_in, blue_in, frame_start
// result    out_valid / out_ready  red_out, green_out, blue_out, row_end, frame_end
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel is accepted per cycle while in_ready is high; the result is registered.
// The rate is set by the line memory, which is read at one column and written
// at another in the same cycle, once each per pixel. A stall at the result port
// backs up stage by stage, so bubbles are squeezed out before in_ready drops.
// Reset clears the counters, window, registers and valids; the line memory is
// not cleared.
`timescale 1ns / 1ps

module rgb_3x3_convolution_filter_top #(
  parameter int MAX_WIDTH = rgbcf_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rgbcf_pkg::CH_W-1:0]     red_in,
  input  logic [rgbcf_pkg::CH_W-1:0]     green_in,
  input  logic [rgbcf_pkg::CH_W-1:0]     blue_in,
  input  logic                           frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rgbcf_pkg::CH_W-1:0]     red_out,
  output logic [rgbcf_pkg::CH_W-1:0]     green_out,
  output logic [rgbcf_pkg::CH_W-1:0]     blue_out,
  output logic                           row_end,
  output logic                           frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rgbcf_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rgbcf_pkg::ROW_BITS-1:0] cfg_data
);

  rgbcf_pkg::kernel_t            kernel;
  logic [rgbcf_pkg::WIDTH_W-1:0]  image_width;
  logic [rgbcf_pkg::HEIGHT_W-1:0] image_height;

  rgbcf_pkg::window_t   win;
  rgbcf_pkg::win_ctrl_t win_ctrl;
  logic                 win_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel[0]    <= rgbcf_pkg::KERNEL_TOP_RST;
      kernel[1]    <= rgbcf_pkg::KERNEL_MIDDLE_RST;
      kernel[2]    <= rgbcf_pkg::KERNEL_BOTTOM_RST;
      image_width  <= rgbcf_pkg::WIDTH_RST;
      image_height <= rgbcf_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (rgbcf_pkg::cfg_reg_t'(cfg_index))
        rgbcf_pkg::REG_KERNEL_TOP:    kernel[0] <= cfg_data;
        rgbcf_pkg::REG_KERNEL_MIDDLE: kernel[1] <= cfg_data;
        rgbcf_pkg::REG_KERNEL_BOTTOM: kernel[2] <= cfg_data;
        rgbcf_pkg::REG_IMAGE_WIDTH:   image_width <= cfg_data[rgbcf_pkg::WIDTH_W-1:0];
        rgbcf_pkg::REG_IMAGE_HEIGHT:  image_height <= cfg_data[rgbcf_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  rgbcf_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pix_in      ({red_in, green_in, blue_in}),
    .frame_start (frame_start),
    .image_width (image_width),
    .image_height(image_height),
    .win         (win),
    .win_ctrl    (win_ctrl),
    .win_ready   (win_ready)
  );

  rgbcf_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .kernel   (kernel),
    .win      (win),
    .win_ctrl (win_ctrl),
    .win_ready(win_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red_out  (red_out),
    .green_out(green_out),
    .blue_out (blue_out),
    .row_end  (row_end),
    .frame_end(frame_end)
  );

endmodule
